### design/dqe_pkg.sv
// ----------------------------------------------------------------------------
// dqe_pkg
// Shared types and constants for the double-ended queue: operation and
// status codes, request and response transfers, controller command and
// datapath status groups.
// ----------------------------------------------------------------------------
package dqe_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5,
        OP_SIZE       = 3'd6,
        OP_CLEAR      = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        op_t                      operation;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [COUNT_W-1:0]       count;
        status_t                  status;
    } rsp_t;

    typedef struct packed {
        logic accept;
        logic capture;
    } ctl_cmd_t;

    typedef struct packed {
        logic rd_req;
    } dp_stat_t;

endpackage

### design/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed 32-bit words held in a ring buffer.
//
// Request channel (req_valid, req_stall, req) carries one operation and a
// value to push. Response channel (rsp_valid, rsp_stall, rsp) returns one
// result per request: the popped or peeked word, the count after the
// operation, and a status (ok, empty on pop or peek, full on push).
// One request is in flight at a time. The result is shown in the cycle after
// the request transfer for pushes, size, clear and pops or peeks on an empty
// queue. Other pops and peeks pass through the controller's read state, which
// captures the word from the element store's registered read port.
// Reset empties the queue and clears the ring front; stored words are not
// cleared and no sweep is needed. While rsp_stall is high the result holds
// and req_stall stays high.
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int CAPACITY = dqe_pkg::CAPACITY
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  dqe_pkg::req_t   req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output dqe_pkg::rsp_t   rsp
);

    dqe_pkg::ctl_cmd_t cmd;
    dqe_pkg::dp_stat_t stat;

    dqe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    dqe_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule

### design/dqe_ram.sv
// ----------------------------------------------------------------------------
// dqe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dqe_ram #(
    parameter int WIDTH = dqe_pkg::DATA_W,
    parameter int DEPTH = dqe_pkg::CAPACITY
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/dqe_ctrl.sv
// ----------------------------------------------------------------------------
// dqe_ctrl
// Controller: sequences one transfer at a time through accept, optional
// element read and result hand-off.
// ----------------------------------------------------------------------------
module dqe_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    input  dqe_pkg::dp_stat_t   stat,
    output dqe_pkg::ctl_cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd.accept  = 1'b0;
        cmd.capture = 1'b0;
        req_stall   = 1'b1;
        rsp_valid   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = stat.rd_req ? S_READ : S_DONE;
                end
            end
            S_READ:
            begin
                cmd.capture = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                rsp_valid = 1'b1;
                if (!rsp_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### design/dqe_dpath.sv
// ----------------------------------------------------------------------------
// dqe_dpath
// Datapath: ring indices, element count, element store and result register.
// ----------------------------------------------------------------------------
module dqe_dpath #(
    parameter int CAPACITY = dqe_pkg::CAPACITY
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dqe_pkg::req_t       req,
    input  dqe_pkg::ctl_cmd_t   cmd,
    output dqe_pkg::dp_stat_t   stat,
    output dqe_pkg::rsp_t       rsp
);

    localparam int IW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int SW   = IW + 1;
    localparam int DW   = dqe_pkg::DATA_W;
    localparam int CNTW = dqe_pkg::COUNT_W;

    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);
    localparam logic [SW-1:0] CAP_SUM  = SW'(CAPACITY);

    logic [IW-1:0]          front_reg;
    logic [IW-1:0]          front_next;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic signed [DW-1:0]   data_reg;
    logic [CW-1:0]          rcount_reg;
    dqe_pkg::status_t       status_reg;
    dqe_pkg::status_t       status_next;

    logic                   is_empty;
    logic                   is_full;
    logic [IW-1:0]          front_dec;
    logic [IW-1:0]          front_inc;
    logic [SW-1:0]          tail_sum;
    logic [SW-1:0]          back_sum;
    logic [IW-1:0]          tail_slot;
    logic [IW-1:0]          back_slot;
    logic                   rd_req;
    logic                   wr_req;
    logic [IW-1:0]          waddr;
    logic [IW-1:0]          raddr;
    logic [DW-1:0]          rdata;

    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == FULL_CNT);
    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - 1'b1;
    assign front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + 1'b1;
    assign tail_sum  = SW'(front_reg) + SW'(count_reg);
    assign back_sum  = tail_sum - SW'(1);
    assign tail_slot = (tail_sum >= CAP_SUM) ? IW'(tail_sum - CAP_SUM) : IW'(tail_sum);
    assign back_slot = (back_sum >= CAP_SUM) ? IW'(back_sum - CAP_SUM) : IW'(back_sum);

    always_comb
    begin
        front_next  = front_reg;
        count_next  = count_reg;
        status_next = dqe_pkg::ST_OK;
        wr_req      = 1'b0;
        rd_req      = 1'b0;
        waddr       = tail_slot;
        raddr       = front_reg;
        case (req.operation)
            dqe_pkg::OP_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    status_next = dqe_pkg::ST_FULL;
                end
                else
                begin
                    wr_req     = 1'b1;
                    waddr      = front_dec;
                    front_next = front_dec;
                    count_next = count_reg + 1'b1;
                end
            end
            dqe_pkg::OP_PUSH_BACK:
            begin
                if (is_full)
                begin
                    status_next = dqe_pkg::ST_FULL;
                end
                else
                begin
                    wr_req     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            dqe_pkg::OP_POP_FRONT:
            begin
                if (is_empty)
                begin
                    status_next = dqe_pkg::ST_EMPTY;
                end
                else
                begin
                    rd_req     = 1'b1;
                    front_next = front_inc;
                    count_next = count_reg - 1'b1;
                end
            end
            dqe_pkg::OP_POP_BACK:
            begin
                if (is_empty)
                begin
                    status_next = dqe_pkg::ST_EMPTY;
                end
                else
                begin
                    rd_req     = 1'b1;
                    raddr      = back_slot;
                    count_next = count_reg - 1'b1;
                end
            end
            dqe_pkg::OP_PEEK_FRONT:
            begin
                if (is_empty)
                begin
                    status_next = dqe_pkg::ST_EMPTY;
                end
                else
                begin
                    rd_req = 1'b1;
                end
            end
            dqe_pkg::OP_PEEK_BACK:
            begin
                if (is_empty)
                begin
                    status_next = dqe_pkg::ST_EMPTY;
                end
                else
                begin
                    rd_req = 1'b1;
                    raddr  = back_slot;
                end
            end
            dqe_pkg::OP_SIZE:
            begin
                status_next = dqe_pkg::ST_OK;
            end
            dqe_pkg::OP_CLEAR:
            begin
                front_next = '0;
                count_next = '0;
            end
            default:
            begin
                status_next = dqe_pkg::ST_OK;
            end
        endcase
    end

    assign stat.rd_req = rd_req;

    dqe_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.accept & wr_req),
        .waddr (waddr),
        .wdata (req.value),
        .re    (cmd.accept & rd_req),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (cmd.accept)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            data_reg   <= '0;
            rcount_reg <= count_next;
            status_reg <= status_next;
        end
        else if (cmd.capture)
        begin
            data_reg <= rdata;
        end
    end

    assign rsp.data   = data_reg;
    assign rsp.count  = CNTW'(rcount_reg);
    assign rsp.status = status_reg;

endmodule

### design/dqe_check.sv
// ----------------------------------------------------------------------------
// dqe_check
// Port-level checks on the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
module dqe_check #(
    parameter int CAPACITY = dqe_pkg::CAPACITY
) (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_stall,
    input logic            rsp_valid,
    input logic            rsp_stall,
    input dqe_pkg::rsp_t   rsp
);

    localparam int CNTW = dqe_pkg::COUNT_W;
    localparam logic [CNTW-1:0] CAP_CNT = CNTW'(CAPACITY);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.count <= CAP_CNT))
        else $error("count above capacity");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == dqe_pkg::ST_FULL) |-> (rsp.count == CAP_CNT))
        else $error("full status with room left");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == dqe_pkg::ST_EMPTY)
            |-> (rsp.count == '0 && rsp.data == '0))
        else $error("empty status with data or elements");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("second request taken while busy");

    a_rsp_single: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_stall) |=> !rsp_valid)
        else $error("result repeated");

endmodule

bind double_ended_queue dqe_check #(.CAPACITY(CAPACITY)) u_check (.*);

### sim/double_ended_queue_test.sv
// ----------------------------------------------------------------------------
// double_ended_queue_test
// Self-checking bench for the ring-buffer double-ended queue. Directed
// operations cover the empty flags, extreme words at both ends, and filling
// past capacity. Random traffic then alternates between filling and draining
// spells. Both sides idle at random but for the last phase, and the traffic
// pauses once per phase until every transfer has come back. Each response
// is checked field by field against an in-bench copy of the queue.
// ----------------------------------------------------------------------------
module double_ended_queue_test;

    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    dqe_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    dqe_pkg::rsp_t rsp;

    int send_idle_pct = 14;
    int rsp_idle_pct = 80;
    int mismatch_count = 0;

    logic signed [dqe_pkg::DATA_W-1:0] q_store [dqe_pkg::CAPACITY];
    int q_front = 0;
    int q_count = 0;
    dqe_pkg::rsp_t queue_results_due [$];

    double_ended_queue i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic dqe_pkg::rsp_t apply_deque_op(dqe_pkg::req_t r);
        dqe_pkg::rsp_t res;
        int slot;
        res.data = '0;
        res.count = '0;
        res.status = dqe_pkg::ST_OK;
        case (r.operation)
            dqe_pkg::OP_PUSH_FRONT, dqe_pkg::OP_PUSH_BACK:
            begin
                if (q_count >= dqe_pkg::CAPACITY)
                    res.status = dqe_pkg::ST_FULL;
                else if (r.operation == dqe_pkg::OP_PUSH_FRONT)
                begin
                    q_front = (q_front + dqe_pkg::CAPACITY - 1) % dqe_pkg::CAPACITY;
                    q_store[q_front] = r.value;
                    q_count++;
                end
                else
                begin
                    q_store[(q_front + q_count) % dqe_pkg::CAPACITY] = r.value;
                    q_count++;
                end
            end
            dqe_pkg::OP_POP_FRONT, dqe_pkg::OP_POP_BACK,
            dqe_pkg::OP_PEEK_FRONT, dqe_pkg::OP_PEEK_BACK:
            begin
                if (q_count == 0)
                    res.status = dqe_pkg::ST_EMPTY;
                else
                begin
                    if (r.operation == dqe_pkg::OP_POP_BACK ||
                        r.operation == dqe_pkg::OP_PEEK_BACK)
                        slot = (q_front + q_count - 1) % dqe_pkg::CAPACITY;
                    else
                        slot = q_front;
                    res.data = q_store[slot];
                    if (r.operation == dqe_pkg::OP_POP_FRONT)
                    begin
                        q_front = (q_front + 1) % dqe_pkg::CAPACITY;
                        q_count--;
                    end
                    else if (r.operation == dqe_pkg::OP_POP_BACK)
                        q_count--;
                end
            end
            dqe_pkg::OP_SIZE: ;
            default:
            begin
                q_front = 0;
                q_count = 0;
            end
        endcase
        res.count = dqe_pkg::COUNT_W'(q_count);
        return res;
    endfunction

    always @(posedge clk)
        rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);

    always @(posedge clk)
    begin
        dqe_pkg::rsp_t due;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (queue_results_due.size() == 0)
            begin
                $display("%0t unexpected transfer: data %0d count %0d status %0d",
                         $time, rsp.data, rsp.count, rsp.status);
                mismatch_count++;
            end
            else
            begin
                due = queue_results_due.pop_front();
                if (rsp.data !== due.data)
                begin
                    $display("%0t data: expected %0d actual %0d", $time, due.data, rsp.data);
                    mismatch_count++;
                end
                if (rsp.count !== due.count)
                begin
                    $display("%0t count: expected %0d actual %0d",
                             $time, due.count, rsp.count);
                    mismatch_count++;
                end
                if (rsp.status !== due.status)
                begin
                    $display("%0t status: expected %0d actual %0d",
                             $time, due.status, rsp.status);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_op(input dqe_pkg::op_t op,
                           input logic signed [dqe_pkg::DATA_W-1:0] v);
        dqe_pkg::req_t item;
        item.operation = op;
        item.value = v;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        req_valid <= 1'b1;
        req <= item;
        do
            @(posedge clk);
        while (req_stall);
        queue_results_due.push_back(apply_deque_op(item));
    endtask

    task automatic hold_until_drained();
        req_valid <= 1'b0;
        while (queue_results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic test_empty_flags();
        send_op(dqe_pkg::OP_POP_FRONT, 32'sd5);
        send_op(dqe_pkg::OP_POP_BACK, -32'sd5);
        send_op(dqe_pkg::OP_PEEK_FRONT, 32'sd0);
        send_op(dqe_pkg::OP_PEEK_BACK, -32'sd1);
    endtask

    task automatic test_extremes();
        send_op(dqe_pkg::OP_PUSH_FRONT, 32'sh7fffffff);
        send_op(dqe_pkg::OP_PUSH_BACK, 32'sh80000000);
        send_op(dqe_pkg::OP_PEEK_FRONT, 32'sd0);
        send_op(dqe_pkg::OP_PEEK_BACK, 32'sd0);
        send_op(dqe_pkg::OP_POP_BACK, 32'sd0);
        send_op(dqe_pkg::OP_POP_FRONT, 32'sd0);
    endtask

    task automatic test_fill_and_overflow();
        for (int i = 0; i < dqe_pkg::CAPACITY; i++)
            send_op((i % 2) ? dqe_pkg::OP_PUSH_BACK : dqe_pkg::OP_PUSH_FRONT,
                    (i % 3) ? -i : i * 1000003);
        send_op(dqe_pkg::OP_PUSH_FRONT, -32'sd1);
        send_op(dqe_pkg::OP_PUSH_BACK, 32'sd1);
        send_op(dqe_pkg::OP_SIZE, 32'sd0);
        send_op(dqe_pkg::OP_CLEAR, 32'sd0);
        send_op(dqe_pkg::OP_SIZE, 32'sd0);
        send_op(dqe_pkg::OP_POP_BACK, 32'sd0);
    endtask

    task automatic test_random_traffic(input int n_items);
        bit filling;
        int pick;
        dqe_pkg::op_t op;
        logic signed [dqe_pkg::DATA_W-1:0] v;
        filling = 1'b1;
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(0, 39) == 0)
                filling = !filling;
            pick = $urandom_range(0, 99);
            if (filling)
                op = (pick < 30) ? dqe_pkg::OP_PUSH_FRONT :
                     (pick < 60) ? dqe_pkg::OP_PUSH_BACK :
                     (pick < 70) ? dqe_pkg::OP_POP_FRONT :
                     (pick < 80) ? dqe_pkg::OP_POP_BACK :
                     (pick < 87) ? dqe_pkg::OP_PEEK_FRONT :
                     (pick < 94) ? dqe_pkg::OP_PEEK_BACK :
                     (pick < 98) ? dqe_pkg::OP_SIZE : dqe_pkg::OP_CLEAR;
            else
                op = (pick < 12) ? dqe_pkg::OP_PUSH_FRONT :
                     (pick < 24) ? dqe_pkg::OP_PUSH_BACK :
                     (pick < 50) ? dqe_pkg::OP_POP_FRONT :
                     (pick < 76) ? dqe_pkg::OP_POP_BACK :
                     (pick < 85) ? dqe_pkg::OP_PEEK_FRONT :
                     (pick < 94) ? dqe_pkg::OP_PEEK_BACK :
                     (pick < 98) ? dqe_pkg::OP_SIZE : dqe_pkg::OP_CLEAR;
            case ($urandom_range(0, 9))
                0: v = 32'sh7fffffff;
                1: v = 32'sh80000000;
                2: v = -32'sd1;
                3: v = 32'sd0;
                default: v = $urandom();
            endcase
            send_op(op, v);
        end
        hold_until_drained();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_flags();
        test_extremes();
        test_fill_and_overflow();
        test_random_traffic(500);

        send_idle_pct = 80;
        rsp_idle_pct = 14;
        test_random_traffic(500);

        send_idle_pct = 0;
        rsp_idle_pct = 0;
        test_random_traffic(500);

        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && queue_results_due.size() == 0)
            $display("[double_ended_queue] OK");
        else
            $display("[double_ended_queue] ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("[double_ended_queue] ERROR");
        $finish;
    end

endmodule

### filelist.f
design/dqe_pkg.sv
design/dqe_ram.sv
design/dqe_ctrl.sv
design/dqe_dpath.sv
design/double_ended_queue.sv
design/dqe_check.sv
sim/double_ended_queue_test.sv
